@@ rtl/rth_pkg.sv @@
// Shared constants for the RGB to HSL converter.
// No dependencies; used by rth_front and rgb_to_hsl_converter.
package rth_pkg;
   localparam int FIELD_BITS = 16;
   localparam int TDATA_BITS = 3 * FIELD_BITS;
endpackage

@@ rtl/rth_front.sv @@
// RGB to HSL front end: extremes, lightness, sector numerators and divisor setup.
// Depends on rth_pkg for field widths; two register stages.
module rth_front #(
   parameter int COLOR_BITS = 16,
   parameter int W = 2 * COLOR_BITS + 4,
   parameter int DW = COLOR_BITS + 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [rth_pkg::FIELD_BITS-1:0]  in_red,
   input  logic [rth_pkg::FIELD_BITS-1:0]  in_green,
   input  logic [rth_pkg::FIELD_BITS-1:0]  in_blue,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [W-1:0]                    out_hue_num,
   output logic [DW-1:0]                   out_hue_den,
   output logic [W-1:0]                    out_sat_num,
   output logic [DW-1:0]                   out_sat_den,
   output logic [COLOR_BITS-1:0]           out_light
);
   localparam int C = COLOR_BITS;
   localparam logic [C:0] FULL = {1'b0, {C{1'b1}}};

   // Stage one: channel extremes.
   logic          v1_ff, v2_ff, en1, en2;
   logic [C-1:0]  r_in, g_in, b_in, mx_in, mn_in;
   logic [C-1:0]  r_ff, g_ff, b_ff, mx_ff, mn_ff;
   logic          rmax_in, gmax_in, rmax_ff, gmax_ff;

   assign en2 = !v2_ff || out_ready;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      r_in = in_red[C-1:0];
      g_in = in_green[C-1:0];
      b_in = in_blue[C-1:0];
      mx_in = r_in;
      mn_in = r_in;
      if (g_in > mx_in) mx_in = g_in;
      if (b_in > mx_in) mx_in = b_in;
      if (g_in < mn_in) mn_in = g_in;
      if (b_in < mn_in) mn_in = b_in;
      rmax_in = (mx_in == r_in);
      gmax_in = !rmax_in && (mx_in == g_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
      if (en1) begin
         r_ff <= r_in;
         g_ff <= g_in;
         b_ff <= b_in;
         mx_ff <= mx_in;
         mn_ff <= mn_in;
         rmax_ff <= rmax_in;
         gmax_ff <= gmax_in;
      end
   end

   // Stage two: numerators and doubled divisors for both rounded divisions.
   logic [C:0]    sum, sden;
   logic [C-1:0]  d;
   logic [C+2:0]  n, d3;
   logic [W-1:0]  hnum_in, snum_in, hn_w, sn_w;
   logic [DW-1:0] hden_in, sden_in;
   logic [C-1:0]  light_in;
   logic [W-1:0]  hnum_ff, snum_ff;
   logic [DW-1:0] hden_ff, sden_ff;
   logic [C-1:0]  light_ff;

   always_comb begin
      sum = {1'b0, mx_ff} + {1'b0, mn_ff};
      d = mx_ff - mn_ff;
      d3 = (C+3)'(d);
      light_in = C'(({1'b0, sum} + (C+2)'(1)) >> 1);
      sden = (sum > FULL) ? ((FULL << 1) - sum) : sum;
      if (rmax_ff) begin
         if (g_ff >= b_ff) n = (C+3)'(g_ff - b_ff);
         else n = (d3 * (C+3)'(6)) - (C+3)'(b_ff - g_ff);
      end else if (gmax_ff) begin
         n = (d3 << 1) + (C+3)'(b_ff) - (C+3)'(r_ff);
      end else begin
         n = (d3 << 2) + (C+3)'(r_ff) - (C+3)'(g_ff);
      end
      if (d == '0) begin
         // Gray pixel: divide zero by one so both quotients come out zero.
         hn_w = '0;
         sn_w = '0;
         hnum_in = W'(1);
         snum_in = W'(1);
         hden_in = DW'(2);
         sden_in = DW'(2);
      end else begin
         hn_w = W'(n);
         sn_w = W'(d);
         // num * 2 * FULL + den, with 2 * FULL formed as a shift and subtract.
         hnum_in = (hn_w << (C + 1)) - (hn_w << 1) + W'(d3 * (C+3)'(6));
         snum_in = (sn_w << (C + 1)) - (sn_w << 1) + W'(sden);
         hden_in = DW'(d3) * DW'(12);
         sden_in = DW'(sden) << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
      if (en2) begin
         hnum_ff <= hnum_in;
         snum_ff <= snum_in;
         hden_ff <= hden_in;
         sden_ff <= sden_in;
         light_ff <= light_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_hue_num = hnum_ff;
   assign out_hue_den = hden_ff;
   assign out_sat_num = snum_ff;
   assign out_sat_den = sden_ff;
   assign out_light = light_ff;
endmodule

@@ rtl/rth_div_stage.sv @@
// One restoring-division step for the hue and saturation quotients.
// No package dependencies; instantiated once per quotient bit.
module rth_div_stage #(
   parameter int COLOR_BITS = 16,
   parameter int W = 2 * COLOR_BITS + 4,
   parameter int DW = COLOR_BITS + 4,
   parameter int SHIFT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [W-1:0]          in_hue_rem,
   input  logic [DW-1:0]         in_hue_den,
   input  logic [COLOR_BITS-1:0] in_hue_q,
   input  logic [W-1:0]          in_sat_rem,
   input  logic [DW-1:0]         in_sat_den,
   input  logic [COLOR_BITS-1:0] in_sat_q,
   input  logic [COLOR_BITS-1:0] in_light,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [W-1:0]          out_hue_rem,
   output logic [DW-1:0]         out_hue_den,
   output logic [COLOR_BITS-1:0] out_hue_q,
   output logic [W-1:0]          out_sat_rem,
   output logic [DW-1:0]         out_sat_den,
   output logic [COLOR_BITS-1:0] out_sat_q,
   output logic [COLOR_BITS-1:0] out_light
);
   localparam int C = COLOR_BITS;

   logic          v_ff, en, hge, sge;
   logic [W-1:0]  hth, sth, hrem_in, srem_in, hrem_ff, srem_ff;
   logic [C-1:0]  hq_in, sq_in, hq_ff, sq_ff, light_ff;
   logic [DW-1:0] hden_ff, sden_ff;

   assign en = !v_ff || out_ready;
   assign in_ready = en;

   always_comb begin
      hth = W'(in_hue_den) << SHIFT;
      sth = W'(in_sat_den) << SHIFT;
      hge = (in_hue_rem >= hth);
      sge = (in_sat_rem >= sth);
      hrem_in = hge ? (in_hue_rem - hth) : in_hue_rem;
      srem_in = sge ? (in_sat_rem - sth) : in_sat_rem;
      hq_in = in_hue_q | (C'(hge) << SHIFT);
      sq_in = in_sat_q | (C'(sge) << SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
      if (en) begin
         hrem_ff <= hrem_in;
         srem_ff <= srem_in;
         hden_ff <= in_hue_den;
         sden_ff <= in_sat_den;
         hq_ff <= hq_in;
         sq_ff <= sq_in;
         light_ff <= in_light;
      end
   end

   assign out_valid = v_ff;
   assign out_hue_rem = hrem_ff;
   assign out_hue_den = hden_ff;
   assign out_hue_q = hq_ff;
   assign out_sat_rem = srem_ff;
   assign out_sat_den = sden_ff;
   assign out_sat_q = sq_ff;
   assign out_light = light_ff;
endmodule

@@ rtl/rgb_to_hsl_converter.sv @@
// RGB to HSL converter: one pixel per beat, hue, saturation and lightness together.
// Throughput is one beat per cycle while the response side accepts every beat.
// Two front stages are followed by one restoring-division stage per quotient bit.
// Every stage holds its beat under back-pressure and moves on when the next stage frees up.
// Reset (synchronous, active high) clears all stage valid bits; data registers are not reset.
// Depends on rth_pkg, rth_front and rth_div_stage.
module rgb_to_hsl_converter #(
   parameter int COLOR_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0 up: red[15:0], green[31:16], blue[47:32].
   input  logic [rth_pkg::TDATA_BITS-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0 up: hue[15:0], saturation[31:16], lightness[47:32].
   output logic [rth_pkg::TDATA_BITS-1:0]  rsp_tdata
);
   localparam int C = COLOR_BITS;
   localparam int W = 2 * C + 4;
   localparam int DW = C + 4;
   localparam int FB = rth_pkg::FIELD_BITS;

   // Stage chain signals; index 0 is the front end's output, index C the last stage.
   logic          v [0:C];
   logic          rdy [0:C];
   logic [W-1:0]  hrem [0:C];
   logic [W-1:0]  srem [0:C];
   logic [DW-1:0] hden [0:C];
   logic [DW-1:0] sden [0:C];
   logic [C-1:0]  hq [0:C];
   logic [C-1:0]  sq [0:C];
   logic [C-1:0]  light [0:C];

   // The front end hands over the numerator and doubled divisor of each
   // rounded quotient, so the division stages need no final correction.
   rth_front #(.COLOR_BITS(C), .W(W), .DW(DW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_red      (req_tdata[FB-1:0]),
      .in_green    (req_tdata[2*FB-1:FB]),
      .in_blue     (req_tdata[3*FB-1:2*FB]),
      .out_valid   (v[0]),
      .out_ready   (rdy[0]),
      .out_hue_num (hrem[0]),
      .out_hue_den (hden[0]),
      .out_sat_num (srem[0]),
      .out_sat_den (sden[0]),
      .out_light   (light[0])
   );

   assign hq[0] = '0;
   assign sq[0] = '0;

   // One quotient bit per stage, most significant first.
   for (genvar j = 0; j < C; j++) begin : g_div
      rth_div_stage #(.COLOR_BITS(C), .W(W), .DW(DW), .SHIFT(C - 1 - j)) u_stage (
         .clock       (clock),
         .reset       (reset),
         .in_valid    (v[j]),
         .in_ready    (rdy[j]),
         .in_hue_rem  (hrem[j]),
         .in_hue_den  (hden[j]),
         .in_hue_q    (hq[j]),
         .in_sat_rem  (srem[j]),
         .in_sat_den  (sden[j]),
         .in_sat_q    (sq[j]),
         .in_light    (light[j]),
         .out_valid   (v[j+1]),
         .out_ready   (rdy[j+1]),
         .out_hue_rem (hrem[j+1]),
         .out_hue_den (hden[j+1]),
         .out_hue_q   (hq[j+1]),
         .out_sat_rem (srem[j+1]),
         .out_sat_den (sden[j+1]),
         .out_sat_q   (sq[j+1]),
         .out_light   (light[j+1])
      );
   end

   // The last stage's registers are the output register.
   assign rdy[C] = rsp_tready;
   assign rsp_tvalid = v[C];
   assign rsp_tdata = {FB'(light[C]), FB'(sq[C]), FB'(hq[C])};
endmodule
